// ===== hdl/mfep_pkg.sv =====
package mfep_pkg;

	typedef enum logic [4:0] {
		PH_HID, PH_HLEN, PH_HFMT, PH_HBODY, PH_TID, PH_TLEN, PH_DELTA, PH_STATUS,
		PH_P1, PH_P2, PH_MTYPE, PH_MLEN, PH_MDATA, PH_SXLEN, PH_PAYLOAD, PH_DONE,
		PH_HALT
	} phase_t;

	localparam logic [2:0] KIND_HEADER  = 3'd0;
	localparam logic [2:0] KIND_CHANNEL = 3'd1;
	localparam logic [2:0] KIND_META    = 3'd2;
	localparam logic [2:0] KIND_VARSTART = 3'd3;
	localparam logic [2:0] KIND_PAYLOAD = 3'd4;
	localparam logic [2:0] KIND_ERROR   = 3'd5;

	localparam logic [2:0] ERR_HEADER   = 3'd0;
	localparam logic [2:0] ERR_SMPTE    = 3'd1;
	localparam logic [2:0] ERR_TRACK_ID = 3'd2;
	localparam logic [2:0] ERR_SYSTEM   = 3'd3;
	localparam logic [2:0] ERR_META_LEN = 3'd4;
	localparam logic [2:0] ERR_CHANNEL  = 3'd5;
	localparam logic [2:0] ERR_VARINT   = 3'd6;

	localparam logic [39:0] ID_MTHD = 40'h4D546864;
	localparam logic [39:0] ID_MTRK = 40'h4D54726B;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       file_start;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [15:0] track_index;
		logic [27:0] delta_time;
		logic [7:0]  status;
		logic [7:0]  param1;
		logic [7:0]  param2;
		logic [39:0] value;
		logic [4:0]  frame_rate;
		logic [7:0]  payload_byte;
		logic        last_payload;
		logic [2:0]  error_code;
	} out_item_t;

	// expected meta length, bit 3 set when the subtype is variable length
	function automatic logic [3:0] fixed_len(input logic [7:0] sub);
		case (sub)
			8'h00: fixed_len = 4'd2;
			8'h20: fixed_len = 4'd1;
			8'h2F: fixed_len = 4'd0;
			8'h51: fixed_len = 4'd3;
			8'h54: fixed_len = 4'd5;
			8'h58: fixed_len = 4'd4;
			8'h59: fixed_len = 4'd2;
			default: fixed_len = 4'd8;
		endcase
	endfunction

	function automatic logic [4:0] smpte_rate(input logic [1:0] code);
		case (code)
			2'd0: smpte_rate = 5'd24;
			2'd1: smpte_rate = 5'd25;
			2'd2: smpte_rate = 5'd29;
			default: smpte_rate = 5'd30;
		endcase
	endfunction

endpackage

// ===== hdl/midi_file_event_parser_top.sv =====
// channel | valid    | stall    | payload
// in      | in_valid | in_stall | in_data  (mfep_pkg::in_item_t)
// out     | out_valid| out_stall| out_data (mfep_pkg::out_item_t)
// one byte is taken per cycle while in_stall is low; each transaction updates the parser state in
// one combinational pass and its result, if any, lands in the output register
// the cycle after. in_stall is high only while a result waits and the sink
// stalls, so bytes stream back to back when the sink keeps up.
// reset puts the parser in the header id phase with all counters at zero.
module midi_file_event_parser_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  mfep_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output mfep_pkg::out_item_t out_data
);

	// parser state
	mfep_pkg::phase_t phase_q, phase_n;
	logic [2:0]  fbc_q, fbc_n;
	logic [27:0] vacc_q, vacc_n;
	logic [7:0]  rs_q, rs_n;
	logic [7:0]  cs_q, cs_n;
	logic [7:0]  sub_q, sub_n;
	logic [27:0] left_q, left_n;
	logic [39:0] fs_q, fs_n;
	logic [15:0] tc_q, tc_n;
	logic [15:0] tt_q, tt_n;
	logic [32:0] chunk_q, chunk_n;
	logic [27:0] hd_q, hd_n;

	logic                emit;
	mfep_pkg::out_item_t res;
	logic                take;

	assign in_stall = out_valid && out_stall;
	assign take = in_valid && !in_stall;

	always_comb begin
		// working copies after optional file restart
		mfep_pkg::phase_t ph;
		logic [2:0]  fbc, fbc1;
		logic [27:0] vacc, vnew;
		logic [39:0] fs, sh;
		logic [15:0] tc, tt, tcn;
		logic [32:0] chunk;
		logic [7:0]  b, rs;
		logic [3:0]  want;
		logic [27:0] lft;
		logic [39:0] v;
		logic        vdone, vlong, one;
		logic [7:0]  eff;

		b = in_data.data_byte;
		if (in_data.file_start) begin
			ph = mfep_pkg::PH_HID; fbc = '0; vacc = '0; rs = '0; fs = '0;
			tc = '0; tt = '0; chunk = '0;
			cs_n = '0; sub_n = '0; left_n = '0; hd_n = '0;
		end else begin
			ph = phase_q; fbc = fbc_q; vacc = vacc_q; rs = rs_q; fs = fs_q;
			tc = tc_q; tt = tt_q; chunk = chunk_q;
			cs_n = cs_q; sub_n = sub_q; left_n = left_q; hd_n = hd_q;
		end
		if (ph >= mfep_pkg::PH_DELTA && ph <= mfep_pkg::PH_PAYLOAD && chunk != '0)
			chunk = chunk - 33'd1;

		fbc1  = fbc + 3'd1;
		sh    = {fs[31:0], b};
		vnew  = {vacc[20:0], b[6:0]};
		vdone = !b[7];
		vlong = b[7] && fbc1 >= 3'd4;
		tcn   = tc + 16'd1;
		want  = mfep_pkg::fixed_len(sub_n);
		lft   = left_n - 28'd1;
		one   = 1'b0;
		eff   = '0;
		v     = '0;

		phase_n = ph; fbc_n = fbc; vacc_n = vacc; rs_n = rs; fs_n = fs;
		tc_n = tc; tt_n = tt; chunk_n = chunk;
		emit = 1'b0;
		res = '0;
		res.track_index = tc;

		unique case (ph)
			mfep_pkg::PH_HID, mfep_pkg::PH_HLEN, mfep_pkg::PH_TID,
			mfep_pkg::PH_HBODY, mfep_pkg::PH_TLEN: begin
				fs_n = sh; fbc_n = fbc1;
				if (fbc1 >= 3'd4) begin
					fbc_n = '0; fs_n = '0;
					case (ph)
						mfep_pkg::PH_HID: begin
							if (sh != mfep_pkg::ID_MTHD) begin
								emit = 1'b1; res.kind = mfep_pkg::KIND_ERROR;
								res.error_code = mfep_pkg::ERR_HEADER;
								phase_n = mfep_pkg::PH_HALT;
							end else phase_n = mfep_pkg::PH_HLEN;
						end
						mfep_pkg::PH_HLEN: begin
							if (sh != 40'd6) begin
								emit = 1'b1; res.kind = mfep_pkg::KIND_ERROR;
								res.error_code = mfep_pkg::ERR_HEADER;
								phase_n = mfep_pkg::PH_HALT;
							end else phase_n = mfep_pkg::PH_HFMT;
						end
						mfep_pkg::PH_TID: begin
							if (sh != mfep_pkg::ID_MTRK) begin
								emit = 1'b1; res.kind = mfep_pkg::KIND_ERROR;
								res.error_code = mfep_pkg::ERR_TRACK_ID;
								phase_n = mfep_pkg::PH_HALT;
							end else phase_n = mfep_pkg::PH_TLEN;
						end
						mfep_pkg::PH_HBODY: begin
							emit = 1'b1;
							if (sh[15]) begin
								res.kind = mfep_pkg::KIND_ERROR;
								res.error_code = mfep_pkg::ERR_SMPTE;
								phase_n = mfep_pkg::PH_HALT;
							end else begin
								tt_n = sh[31:16]; tc_n = '0;
								res.track_index = '0;
								res.kind = mfep_pkg::KIND_HEADER;
								res.value = {8'd0, sh[31:0]};
								phase_n = (sh[31:16] == '0) ? mfep_pkg::PH_DONE
									: mfep_pkg::PH_TID;
							end
						end
						default: begin
							// track length
							chunk_n = {1'b0, sh[31:0]};
							rs_n = '0;
							if (sh[31:0] == '0) begin
								tc_n = tcn;
								phase_n = (tcn == tt) ? mfep_pkg::PH_DONE
									: mfep_pkg::PH_TID;
							end else begin
								vacc_n = '0;
								phase_n = mfep_pkg::PH_DELTA;
							end
						end
					endcase
				end
			end
			mfep_pkg::PH_HFMT: begin
				fbc_n = fbc1;
				if (fbc1 >= 3'd2) begin
					fbc_n = '0; fs_n = '0; phase_n = mfep_pkg::PH_HBODY;
				end
			end
			mfep_pkg::PH_DELTA, mfep_pkg::PH_MLEN, mfep_pkg::PH_SXLEN: begin
				vacc_n = vnew; fbc_n = fbc1;
				if (vdone) begin
					if (ph == mfep_pkg::PH_DELTA) begin
						hd_n = vnew; phase_n = mfep_pkg::PH_STATUS;
					end else if (ph == mfep_pkg::PH_SXLEN || want[3]) begin
						emit = 1'b1;
						res.kind = mfep_pkg::KIND_VARSTART;
						res.delta_time = hd_n; res.status = cs_n;
						res.param1 = sub_n; res.param2 = 8'hFF;
						res.value = {12'd0, vnew};
						if (vnew == '0) one = 1'b1;
						else begin
							left_n = vnew; phase_n = mfep_pkg::PH_PAYLOAD;
						end
					end else if (vnew != {24'd0, want}) begin
						emit = 1'b1; res.kind = mfep_pkg::KIND_ERROR;
						res.error_code = mfep_pkg::ERR_META_LEN;
						phase_n = mfep_pkg::PH_HALT;
					end else if (want == 4'd0) begin
						emit = 1'b1; res.kind = mfep_pkg::KIND_META;
						res.delta_time = hd_n; res.status = 8'hFF;
						res.param1 = sub_n; res.param2 = 8'hFF;
						one = 1'b1;
					end else begin
						left_n = {24'd0, want}; fs_n = '0;
						phase_n = mfep_pkg::PH_MDATA;
					end
				end else if (vlong) begin
					emit = 1'b1; res.kind = mfep_pkg::KIND_ERROR;
					res.error_code = mfep_pkg::ERR_VARINT;
					phase_n = mfep_pkg::PH_HALT;
				end
			end
			mfep_pkg::PH_STATUS: begin
				if (b[7:4] == 4'hF) begin
					if (b == 8'hFF) begin
						cs_n = 8'hFF; phase_n = mfep_pkg::PH_MTYPE;
					end else if (b == 8'hF0 || b == 8'hF7) begin
						cs_n = b; sub_n = '0; vacc_n = '0; fbc_n = '0;
						phase_n = mfep_pkg::PH_SXLEN;
					end else begin
						emit = 1'b1; res.kind = mfep_pkg::KIND_ERROR;
						res.error_code = mfep_pkg::ERR_SYSTEM;
						phase_n = mfep_pkg::PH_HALT;
					end
				end else if (b[7]) begin
					cs_n = b; rs_n = b; phase_n = mfep_pkg::PH_P1;
				end else begin
					eff = rs; cs_n = rs;
					if (!rs[7]) begin
						emit = 1'b1; res.kind = mfep_pkg::KIND_ERROR;
						res.error_code = mfep_pkg::ERR_CHANNEL;
						phase_n = mfep_pkg::PH_HALT;
					end else if (rs[7:4] == 4'hC || rs[7:4] == 4'hD) begin
						emit = 1'b1; res.kind = mfep_pkg::KIND_CHANNEL;
						res.delta_time = hd_n; res.status = eff;
						res.param1 = b; res.param2 = 8'hFF; one = 1'b1;
					end else begin
						fs_n = {32'd0, b}; phase_n = mfep_pkg::PH_P2;
					end
				end
			end
			mfep_pkg::PH_P1: begin
				if (cs_n[7:4] == 4'hC || cs_n[7:4] == 4'hD) begin
					emit = 1'b1; res.kind = mfep_pkg::KIND_CHANNEL;
					res.delta_time = hd_n; res.status = cs_n;
					res.param1 = b; res.param2 = 8'hFF; one = 1'b1;
				end else begin
					fs_n = {32'd0, b}; phase_n = mfep_pkg::PH_P2;
				end
			end
			mfep_pkg::PH_P2: begin
				emit = 1'b1; res.kind = mfep_pkg::KIND_CHANNEL;
				res.delta_time = hd_n; res.status = cs_n;
				res.param1 = fs[7:0]; res.param2 = b; one = 1'b1;
			end
			mfep_pkg::PH_MTYPE: begin
				sub_n = b; vacc_n = '0; fbc_n = '0;
				phase_n = mfep_pkg::PH_MLEN;
			end
			mfep_pkg::PH_MDATA: begin
				fs_n = sh;
				if (left_n != '0) left_n = lft;
				if (left_n == '0) begin
					v = sh;
					emit = 1'b1; res.kind = mfep_pkg::KIND_META;
					res.delta_time = hd_n; res.status = 8'hFF;
					res.param1 = sub_n; res.param2 = 8'hFF;
					if (sub_n == 8'h54) begin
						res.frame_rate = mfep_pkg::smpte_rate(sh[38:37]);
						v[39:37] = 3'd0;
					end
					res.value = v; one = 1'b1;
				end
			end
			mfep_pkg::PH_PAYLOAD: begin
				if (left_n != '0) left_n = lft;
				emit = 1'b1; res.kind = mfep_pkg::KIND_PAYLOAD;
				res.delta_time = hd_n; res.status = cs_n;
				res.param1 = sub_n; res.param2 = 8'hFF;
				res.payload_byte = b; res.last_payload = (left_n == '0);
				one = (left_n == '0);
			end
			default: ;
		endcase

		// end of event: next delta or end of track
		if (one) begin
			if (chunk == '0) begin
				tc_n = tcn; fbc_n = '0; fs_n = '0;
				phase_n = (tcn == tt) ? mfep_pkg::PH_DONE : mfep_pkg::PH_TID;
			end else begin
				vacc_n = '0; fbc_n = '0; phase_n = mfep_pkg::PH_DELTA;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= mfep_pkg::PH_HID;
			fbc_q <= '0; vacc_q <= '0; rs_q <= '0; cs_q <= '0; sub_q <= '0;
			left_q <= '0; fs_q <= '0; tc_q <= '0; tt_q <= '0; chunk_q <= '0;
			hd_q <= '0; out_valid <= 1'b0;
		end else begin
			if (take) begin
				phase_q <= phase_n; fbc_q <= fbc_n; vacc_q <= vacc_n; rs_q <= rs_n;
				cs_q <= cs_n; sub_q <= sub_n; left_q <= left_n; fs_q <= fs_n;
				tc_q <= tc_n; tt_q <= tt_n; chunk_q <= chunk_n; hd_q <= hd_n;
			end
			if (!in_stall) out_valid <= take && emit;
		end
	end

	// result register, held while stalled
	always_ff @(posedge clk) begin
		if (take && emit) out_data <= res;
	end

endmodule

// ===== tb/midi_event_checker.sv =====
module midi_event_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_stall,
	input  mfep_pkg::in_item_t  in_data,
	input  logic                out_valid,
	input  logic                out_stall,
	input  mfep_pkg::out_item_t out_data,
	output int                  fail_count,
	output int                  pending_count
);

	mfep_pkg::phase_t ph;
	logic [2:0]  fcnt;
	logic [27:0] vacc;
	logic [7:0]  run_st, cur_st, msub;
	logic [27:0] ev_left;
	logic [39:0] fshift;
	logic [15:0] trk, trk_total;
	logic [32:0] chunk_left;
	logic [27:0] hdelta;

	mfep_pkg::out_item_t events_due[$];

	task automatic parser_clear();
		ph = mfep_pkg::PH_HID; fcnt = 0; vacc = 0; run_st = 0; cur_st = 0; msub = 0;
		ev_left = 0; fshift = 0; trk = 0; trk_total = 0; chunk_left = 0; hdelta = 0;
	endtask

	task automatic emit(logic [2:0] k, logic [27:0] d, logic [7:0] st, logic [7:0] p1,
			logic [7:0] p2, logic [39:0] v, logic [4:0] fr, logic [7:0] pb,
			logic lst, logic [2:0] e);
		mfep_pkg::out_item_t o;
		o.kind = k; o.track_index = trk; o.delta_time = d; o.status = st;
		o.param1 = p1; o.param2 = p2; o.value = v; o.frame_rate = fr;
		o.payload_byte = pb; o.last_payload = lst; o.error_code = e;
		events_due = {events_due, o};
	endtask

	task automatic halt_with(logic [2:0] e);
		emit(mfep_pkg::KIND_ERROR, 0, 0, 0, 0, 0, 0, 0, 0, e);
		ph = mfep_pkg::PH_HALT;
	endtask

	function automatic bit shift_in4(logic [7:0] b);
		fshift = {fshift[31:0], b};
		fcnt = fcnt + 3'd1;
		if (fcnt >= 4) begin
			fcnt = 0;
			return 1;
		end
		return 0;
	endfunction

	// 1 done, 0 more, -1 too long
	function automatic int varint_in(logic [7:0] b);
		vacc = {vacc[20:0], b[6:0]};
		fcnt = fcnt + 3'd1;
		if (!b[7]) return 1;
		return (fcnt >= 4) ? -1 : 0;
	endfunction

	task automatic next_track();
		trk = trk + 16'd1; fcnt = 0; fshift = 0;
		ph = (trk == trk_total) ? mfep_pkg::PH_DONE : mfep_pkg::PH_TID;
	endtask

	task automatic event_done();
		if (chunk_left == 0) next_track();
		else begin
			vacc = 0; fcnt = 0; ph = mfep_pkg::PH_DELTA;
		end
	endtask

	task automatic var_start(logic [27:0] len);
		emit(mfep_pkg::KIND_VARSTART, hdelta, cur_st, msub, 8'hff, {12'd0, len}, 0, 0, 0, 0);
		if (len == 0) event_done();
		else begin
			ev_left = len; ph = mfep_pkg::PH_PAYLOAD;
		end
	endtask

	task automatic chan_event(logic [7:0] p1, logic [7:0] p2);
		emit(mfep_pkg::KIND_CHANNEL, hdelta, cur_st, p1, p2, 0, 0, 0, 0, 0);
		event_done();
	endtask

	function automatic bit single_data(logic [7:0] st);
		return st[7:4] == 4'hc || st[7:4] == 4'hd;
	endfunction

	function automatic int meta_len(logic [7:0] s);
		case (s)
			8'h00: return 2;
			8'h20: return 1;
			8'h2f: return 0;
			8'h51: return 3;
			8'h54: return 5;
			8'h58: return 4;
			8'h59: return 2;
			default: return -1;
		endcase
	endfunction

	task automatic parse_byte(mfep_pkg::in_item_t it);
		logic [7:0] b;
		int r, want;
		logic [39:0] v;
		logic [4:0] fr;
		b = it.data_byte;
		if (it.file_start) parser_clear();
		if (ph >= mfep_pkg::PH_DELTA && ph <= mfep_pkg::PH_PAYLOAD && chunk_left > 0)
			chunk_left--;
		case (ph)
			mfep_pkg::PH_HID: if (shift_in4(b)) begin
				if (fshift != mfep_pkg::ID_MTHD) halt_with(mfep_pkg::ERR_HEADER);
				else begin fshift = 0; ph = mfep_pkg::PH_HLEN; end
			end
			mfep_pkg::PH_HLEN: if (shift_in4(b)) begin
				if (fshift != 40'd6) halt_with(mfep_pkg::ERR_HEADER);
				else begin fshift = 0; ph = mfep_pkg::PH_HFMT; end
			end
			mfep_pkg::PH_HFMT: begin
				fcnt = fcnt + 3'd1;
				if (fcnt >= 2) begin fcnt = 0; fshift = 0; ph = mfep_pkg::PH_HBODY; end
			end
			mfep_pkg::PH_HBODY: if (shift_in4(b)) begin
				if (fshift[15]) halt_with(mfep_pkg::ERR_SMPTE);
				else begin
					trk_total = fshift[31:16];
					trk = 0;
					emit(mfep_pkg::KIND_HEADER, 0, 0, 0, 0, {8'h0, fshift[31:0]}, 0, 0, 0, 0);
					fshift = 0;
					ph = (trk_total == 0) ? mfep_pkg::PH_DONE : mfep_pkg::PH_TID;
				end
			end
			mfep_pkg::PH_TID: if (shift_in4(b)) begin
				if (fshift != mfep_pkg::ID_MTRK) halt_with(mfep_pkg::ERR_TRACK_ID);
				else begin fshift = 0; ph = mfep_pkg::PH_TLEN; end
			end
			mfep_pkg::PH_TLEN: if (shift_in4(b)) begin
				chunk_left = {1'b0, fshift[31:0]};
				fshift = 0; run_st = 0;
				if (chunk_left == 0) next_track();
				else begin vacc = 0; fcnt = 0; ph = mfep_pkg::PH_DELTA; end
			end
			mfep_pkg::PH_DELTA: begin
				r = varint_in(b);
				if (r < 0) halt_with(mfep_pkg::ERR_VARINT);
				else if (r > 0) begin hdelta = vacc; ph = mfep_pkg::PH_STATUS; end
			end
			mfep_pkg::PH_STATUS: begin
				if (b[7:4] == 4'hf) begin
					if (b == 8'hff) begin cur_st = b; ph = mfep_pkg::PH_MTYPE; end
					else if (b == 8'hf0 || b == 8'hf7) begin
						cur_st = b; msub = 0; vacc = 0; fcnt = 0; ph = mfep_pkg::PH_SXLEN;
					end else halt_with(mfep_pkg::ERR_SYSTEM);
				end else if (b[7]) begin
					cur_st = b; run_st = b; ph = mfep_pkg::PH_P1;
				end else begin
					cur_st = run_st;
					if (!cur_st[7]) halt_with(mfep_pkg::ERR_CHANNEL);
					else if (single_data(cur_st)) chan_event(b, 8'hff);
					else begin fshift = {32'd0, b}; ph = mfep_pkg::PH_P2; end
				end
			end
			mfep_pkg::PH_P1: begin
				if (single_data(cur_st)) chan_event(b, 8'hff);
				else begin fshift = {32'd0, b}; ph = mfep_pkg::PH_P2; end
			end
			mfep_pkg::PH_P2: chan_event(fshift[7:0], b);
			mfep_pkg::PH_MTYPE: begin
				msub = b; vacc = 0; fcnt = 0; ph = mfep_pkg::PH_MLEN;
			end
			mfep_pkg::PH_MLEN: begin
				r = varint_in(b);
				if (r < 0) halt_with(mfep_pkg::ERR_VARINT);
				else if (r > 0) begin
					want = meta_len(msub);
					if (want < 0) var_start(vacc);
					else if (vacc != 28'(want)) halt_with(mfep_pkg::ERR_META_LEN);
					else if (want == 0) begin
						emit(mfep_pkg::KIND_META, hdelta, 8'hff, msub, 8'hff, 0, 0, 0, 0, 0);
						event_done();
					end else begin
						ev_left = 28'(want); fshift = 0; ph = mfep_pkg::PH_MDATA;
					end
				end
			end
			mfep_pkg::PH_MDATA: begin
				fshift = {fshift[31:0], b};
				if (ev_left > 0) ev_left--;
				if (ev_left == 0) begin
					v = fshift; fr = 0;
					if (msub == 8'h54) begin
						case (v[38:37])
							2'd0: fr = 24;
							2'd1: fr = 25;
							2'd2: fr = 29;
							default: fr = 30;
						endcase
						v[39:37] = 3'b000;
					end
					emit(mfep_pkg::KIND_META, hdelta, 8'hff, msub, 8'hff, v, fr, 0, 0, 0);
					event_done();
				end
			end
			mfep_pkg::PH_SXLEN: begin
				r = varint_in(b);
				if (r < 0) halt_with(mfep_pkg::ERR_VARINT);
				else if (r > 0) var_start(vacc);
			end
			mfep_pkg::PH_PAYLOAD: begin
				if (ev_left > 0) ev_left--;
				emit(mfep_pkg::KIND_PAYLOAD, hdelta, cur_st, msub, 8'hff, 0, 0, b,
					ev_left == 0, 0);
				if (ev_left == 0) event_done();
			end
			default: ;
		endcase
	endtask

	assign pending_count = events_due.size();

	initial begin
		parser_clear();
		fail_count = 0;
	end

	always @(posedge clk) begin
		mfep_pkg::out_item_t exp_ev;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (events_due.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected event %h", out_data);
				end else begin
					exp_ev = events_due.pop_front();
					if (exp_ev !== out_data) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch exp %h got %h", exp_ev, out_data);
					end
				end
			end
			if (in_valid && !in_stall) parse_byte(in_data);
		end
	end
endmodule

// ===== tb/midi_file_event_parser_top_tb.sv =====
module midi_file_event_parser_top_tb;

	logic                clk = 0;
	logic                arst_n = 0;
	logic                in_valid = 0;
	logic                in_stall;
	mfep_pkg::in_item_t  in_data = '0;
	logic                out_valid;
	logic                out_stall = 0;
	mfep_pkg::out_item_t out_data;
	int                  fail_count, pending_count;
	int                  cycle_count = 0;

	// file under construction, streamed by send_file
	logic [7:0] file_bytes[$];
	int         bytes_sent = 0;

	midi_file_event_parser_top dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
		.out_data(out_data)
	);

	midi_event_checker checker_i (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
		.out_data(out_data), .fail_count(fail_count), .pending_count(pending_count)
	);

	initial forever #2 clk = ~clk;

	// global watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > 400000) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// mostly short gaps, a few long ones
	function automatic int gap_len();
		if ($urandom_range(0, 19) == 0) return $urandom_range(8, 40);
		if ($urandom_range(0, 2) == 0) return 0;
		return $urandom_range(0, 3);
	endfunction

	// sink stall pattern, with stretches of no stall
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			out_stall <= 0;
			n = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) : gap_len();
			repeat (n) @(negedge clk);
			out_stall <= 1;
			n = gap_len();
			repeat (n) @(negedge clk);
		end
	end

	// send one byte and hold until the transaction is accepted
	task automatic send_byte(logic [7:0] b, logic fs, bit idle_ok);
		int g;
		g = idle_ok ? gap_len() : 0;
		if (g > 0) begin
			in_valid <= 0;
			repeat (g) @(negedge clk);
		end
		in_valid <= 1;
		in_data <= '{data_byte: b, file_start: fs};
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		bytes_sent++;
	endtask

	task automatic send_file(bit idle_ok);
		foreach (file_bytes[i]) send_byte(file_bytes[i], i == 0, idle_ok);
		file_bytes.delete();
	endtask

	task automatic append_byte(logic [7:0] b);
		file_bytes = {file_bytes, b};
	endtask

	task automatic put4(logic [31:0] w);
		append_byte(w[31:24]); append_byte(w[23:16]);
		append_byte(w[15:8]);  append_byte(w[7:0]);
	endtask

	task automatic put_header(logic [15:0] ntrk, logic [15:0] div);
		put4(32'h4d546864); put4(6); put4({16'h0001, ntrk}); put4({16'h0000, div}) ;
		// put4 above pushed format+count then division with a zero hi word; swap in the two division bytes
		repeat (4) void'(file_bytes.pop_back());
		append_byte(div[15:8]); append_byte(div[7:0]);
	endtask

	task automatic put_varint(logic [27:0] v, int force_len);
		int n;
		n = 1;
		if (v >= 28'h80) n = 2;
		if (v >= 28'h4000) n = 3;
		if (v >= 28'h200000) n = 4;
		if (force_len > n) n = force_len;
		for (int i = n - 1; i >= 0; i--)
			append_byte({i != 0, 7'((v >> (7 * i)) & 7'h7f)});
	endtask

	// one random event into a byte queue, mostly well formed
	task automatic rand_event(ref logic [7:0] ev[$], inout logic [7:0] rs);
		logic [7:0] st, sub;
		int len, sel;
		logic [7:0] fix_subs[7] = '{8'h00, 8'h20, 8'h2f, 8'h51, 8'h54, 8'h58, 8'h59};
		logic [7:0] saved[$];
		saved = file_bytes;
		file_bytes = {};
		put_varint($urandom_range(0, 3) == 0 ? 28'($urandom() & 28'hfffffff)
			: 28'($urandom_range(0, 200)), $urandom_range(0, 4));
		sel = $urandom_range(0, 99);
		if (sel < 50) begin
			st = {1'b1, 3'($urandom()), 4'($urandom())};
			if (rs[7] && $urandom_range(0, 1)) st = rs;
			else append_byte(st);
			rs = st;
			append_byte(8'($urandom_range(0, 127)));
			if (st[7:4] != 4'hc && st[7:4] != 4'hd)
				append_byte(8'($urandom_range(0, 127)));
		end else if (sel < 75) begin
			sub = fix_subs[$urandom_range(0, 6)];
			append_byte(8'hff); append_byte(sub);
			case (sub)
				8'h00: len = 2; 8'h20: len = 1; 8'h2f: len = 0; 8'h51: len = 3;
				8'h54: len = 5; 8'h58: len = 4; default: len = 2;
			endcase
			if ($urandom_range(0, 40) == 0) len = len + 1;
			put_varint(28'(len), 0);
			repeat (len) append_byte(8'($urandom()));
		end else if (sel < 95) begin
			if ($urandom_range(0, 1)) begin
				append_byte(8'hff);
				append_byte($urandom_range(0, 1) ? 8'($urandom_range(1, 15))
					: 8'($urandom()));
			end else append_byte($urandom_range(0, 1) ? 8'hf0 : 8'hf7);
			len = $urandom_range(0, 6);
			put_varint(28'(len), $urandom_range(0, 2));
			repeat (len) append_byte(8'($urandom()));
		end else begin
			// noise in status position or an over long varint
			if ($urandom_range(0, 1)) append_byte(8'($urandom()));
			else repeat (4) append_byte(8'($urandom() | 32'h80));
		end
		ev = file_bytes;
		file_bytes = saved;
	endtask

	task automatic build_rand_file();
		int ntrk, nev;
		logic [7:0] rs;
		logic [7:0] body[$], ev[$];
		ntrk = $urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 3);
		put_header(16'(ntrk), $urandom_range(0, 15) == 0 ? 16'(32'h8000 | $urandom())
			: 16'($urandom() & 32'h7fff));
		if ($urandom_range(0, 25) == 0) file_bytes[5] = 7;
		for (int t = 0; t < ntrk; t++) begin
			body = {}; rs = 0;
			nev = $urandom_range(0, 6);
			for (int e = 0; e < nev; e++) begin
				rand_event(ev, rs);
				body = {body, ev};
			end
			if ($urandom_range(0, 30) == 0) put4(32'h4d54726c); else put4(32'h4d54726b);
			// sometimes lie about length to cause an overrun
			put4($urandom_range(0, 8) == 0 ? 32'($urandom_range(0, body.size()))
				: 32'(body.size()));
			file_bytes = {file_bytes, body};
		end
		repeat ($urandom_range(0, 3)) append_byte(8'($urandom()));
	endtask

	initial begin
		logic [7:0] rs;
		logic [7:0] ev[$];
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;
		@(negedge clk);

		// directed: header, extreme bytes, smpte meta, running status
		put_header(1, 16'h7fff); put4(32'h4d54726b); put4(30);
		file_bytes = {file_bytes, 8'h00, 8'h90, 8'h00, 8'h7f, 8'h7f, 8'h00, 8'h7f,
			8'h00, 8'hc5, 8'h7f, 8'h00, 8'hff, 8'h54, 8'h05, 8'hff, 8'hff,
			8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'h7f,
			8'h00, 8'hff, 8'h2f, 8'h00, 8'h00, 8'h00, 8'h00};
		send_file(0);
		// bad system status, then smpte division, then bad id
		put_header(1, 16'h60); put4(32'h4d54726b); put4(4);
		file_bytes = {file_bytes, 8'h00, 8'hf3};
		send_file(1);
		put_header(2, 16'hffff); send_file(1);
		put4(32'h00000000); send_file(1);

		// wait until everything is out before going on
		while (pending_count != 0) @(negedge clk);
		repeat (4) @(negedge clk);

		while (bytes_sent < 1950) begin
			build_rand_file();
			send_file($urandom_range(0, 3) != 0);
		end
		in_valid <= 0;

		while (pending_count != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		if (fail_count == 0) $display("TEST PASSED");
		else $display("TEST FAILED");
		$finish;
	end
endmodule
